>>> src/dmbp_pkg.sv
// ----------------------------------------------------------------------------
// Depth map back-projection package
// Shared constants, register indexes and configuration structures.
// ----------------------------------------------------------------------------
package dmbp_pkg;

   localparam int MAX_COLS_DEF = 4096;
   localparam int MAX_ROWS_DEF = 4096;

   // Depth of the queue between the front and the back.
   localparam int MID_DEPTH = 4;
   // Depth of the result queue at the output.
   localparam int OUT_DEPTH = 8;
   // Register stages in one projection pipeline.
   localparam int PROJ_LAT = 5;

   localparam int COORD_W = 24;
   localparam int DEPTH_W = 16;
   localparam int PIX_W   = 12;

   localparam logic [15:0] RST_DEPTH_LO    = 16'd0;
   localparam logic [15:0] RST_DEPTH_HI    = 16'd65535;
   localparam logic [15:0] RST_CENTER_X    = 16'd5120;
   localparam logic [15:0] RST_CENTER_Y    = 16'd3840;
   localparam logic [31:0] RST_INV_FOCAL   = 32'd8589934;
   localparam logic [5:0]  RST_DEC_STEP    = 6'd1;
   localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;

   typedef enum logic [3:0] {
      REG_DEPTH_LO    = 4'd0,
      REG_DEPTH_HI    = 4'd1,
      REG_CENTER_X    = 4'd2,
      REG_CENTER_Y    = 4'd3,
      REG_INV_FOCAL_X = 4'd4,
      REG_INV_FOCAL_Y = 4'd5,
      REG_DEC_STEP    = 4'd6,
      REG_IMAGE_WIDTH = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [15:0] depth_lo;
      logic [15:0] depth_hi;
      logic [5:0]  dec_step;
      logic [12:0] image_width;
   } front_cfg_type;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [31:0] inv_focal_x;
      logic [31:0] inv_focal_y;
   } back_cfg_type;

endpackage

>>> src/dmbp_queue.sv
// ----------------------------------------------------------------------------
// Register queue
// Small first-in first-out buffer with a fill count, read at its head.
// ----------------------------------------------------------------------------
module dmbp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic [$clog2(DEPTH+1)-1:0]     count
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

>>> src/dmbp_front.sv
// ----------------------------------------------------------------------------
// Raster front end
// Tracks pixel position and decimation phase, and decides which pixels pass.
// ----------------------------------------------------------------------------
module dmbp_front
   import dmbp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [DEPTH_W-1:0]            depth_mm,
   input  logic                          frame_start,
   input  front_cfg_type                 cfg,
   output logic                          keep,
   output logic [$clog2(MAX_COLS)-1:0]   col,
   output logic [$clog2(MAX_ROWS)-1:0]   row
);

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   logic [5:0]    col_phase_ff, col_phase_in, col_phase_cur;
   logic [5:0]    row_phase_ff, row_phase_in, row_phase_cur;
   logic [5:0]    step;
   logic [WW-1:0] width_raw, width_eff, col_inc;
   logic [RW:0]   row_inc;
   logic [6:0]    col_ph_inc, row_ph_inc;
   logic          depth_ok;

   always_comb begin
      step = (cfg.dec_step == 6'd0) ? 6'd1 : cfg.dec_step;
      width_raw = WW'(cfg.image_width);
      if (width_raw == '0) begin
         width_eff = WW'(1);
      end else if (width_raw > WW'(MAX_COLS)) begin
         width_eff = WW'(MAX_COLS);
      end else begin
         width_eff = width_raw;
      end

      col_cur       = frame_start ? '0 : col_ff;
      row_cur       = frame_start ? '0 : row_ff;
      col_phase_cur = frame_start ? '0 : col_phase_ff;
      row_phase_cur = frame_start ? '0 : row_phase_ff;

      depth_ok = (depth_mm != '0) && (depth_mm >= cfg.depth_lo) &&
                 (depth_mm <= cfg.depth_hi);
      keep = (col_phase_cur == 6'd0) && (row_phase_cur == 6'd0) && depth_ok;

      col_inc    = WW'(col_cur) + WW'(1);
      row_inc    = (RW+1)'(row_cur) + (RW+1)'(1);
      col_ph_inc = {1'b0, col_phase_cur} + 7'd1;
      row_ph_inc = {1'b0, row_phase_cur} + 7'd1;

      col_in       = col_cur;
      row_in       = row_cur;
      col_phase_in = col_phase_cur;
      row_phase_in = row_phase_cur;
      if (col_inc >= width_eff) begin
         col_in       = '0;
         col_phase_in = '0;
         // The row counter holds at its last value, and its phase with it.
         if (row_inc < (RW+1)'(MAX_ROWS)) begin
            row_in       = row_inc[RW-1:0];
            row_phase_in = (row_ph_inc >= {1'b0, step}) ? 6'd0 : row_ph_inc[5:0];
         end
      end else begin
         col_in       = col_inc[CW-1:0];
         col_phase_in = (col_ph_inc >= {1'b0, step}) ? 6'd0 : col_ph_inc[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
      end else if (accept) begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
      end
   end

   assign col = col_cur;
   assign row = row_cur;

endmodule

>>> src/dmbp_proj.sv
// ----------------------------------------------------------------------------
// Axis projection pipeline
// Five stages computing floor((16*pos - center) * d * inv / 2^36), saturated.
// ----------------------------------------------------------------------------
module dmbp_proj
   import dmbp_pkg::*;
#(
   parameter int PW = 12
) (
   input  logic                      clock,
   input  logic [PW-1:0]             pos,
   input  logic [15:0]               center,
   input  logic [DEPTH_W-1:0]        depth,
   input  logic [31:0]               inv,
   output logic signed [COORD_W-1:0] coord
);

   localparam int MW = (PW + 4 > 16) ? PW + 4 : 16;
   localparam int QW = MW + 13;

   logic [MW:0]          pos16, cen, diff, diff_neg;
   logic                 s1_neg_ff, s2_neg_ff, s3_neg_ff, s4_neg_ff;
   logic [MW-1:0]        s1_mag_ff, s1_mag_in;
   logic [DEPTH_W-1:0]   s1_d_ff;
   logic [MW+15:0]       s2_prod_ff, s2_prod_in;
   logic [MW+31:0]       s3_hi_ff, s3_hi_in, s3_lo_ff, s3_lo_in;
   logic [MW+47:0]       s4_full;
   logic [MW+11:0]       s4_q_ff;
   logic                 s4_rem_ff;
   logic [QW-1:0]        q_ext, qr;
   logic [COORD_W-1:0]   s5_coord_ff, s5_coord_in;

   always_comb begin
      pos16     = (MW+1)'({pos, 4'b0000});
      cen       = (MW+1)'(center);
      diff      = pos16 - cen;
      diff_neg  = -diff;
      s1_mag_in = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];

      s2_prod_in = (MW+16)'(s1_mag_ff) * (MW+16)'(s1_d_ff);

      s3_hi_in = (MW+32)'(s2_prod_ff) * (MW+32)'(inv[31:16]);
      s3_lo_in = (MW+32)'(s2_prod_ff) * (MW+32)'(inv[15:0]);

      s4_full = {s3_hi_ff, 16'h0000} + (MW+48)'(s3_lo_ff);

      // Negative values round toward minus infinity: magnitude rounds up.
      q_ext = QW'(s4_q_ff);
      qr    = q_ext + QW'(s4_rem_ff);
      if (s4_neg_ff) begin
         if (qr > QW'(24'h800000)) begin
            s5_coord_in = 24'h800000;
         end else begin
            s5_coord_in = -qr[COORD_W-1:0];
         end
      end else begin
         if (q_ext > QW'(24'h7FFFFF)) begin
            s5_coord_in = 24'h7FFFFF;
         end else begin
            s5_coord_in = q_ext[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_neg_ff   <= diff[MW];
      s1_mag_ff   <= s1_mag_in;
      s1_d_ff     <= depth;
      s2_neg_ff   <= s1_neg_ff;
      s2_prod_ff  <= s2_prod_in;
      s3_neg_ff   <= s2_neg_ff;
      s3_hi_ff    <= s3_hi_in;
      s3_lo_ff    <= s3_lo_in;
      s4_neg_ff   <= s3_neg_ff;
      s4_q_ff     <= s4_full[MW+47:36];
      s4_rem_ff   <= |s4_full[35:0];
      s5_coord_ff <= s5_coord_in;
   end

   assign coord = s5_coord_ff;

endmodule

>>> src/dmbp_back.sv
// ----------------------------------------------------------------------------
// Projection back end
// Issues queued points into the two axis pipelines and buffers the results.
// ----------------------------------------------------------------------------
module dmbp_back
   import dmbp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  back_cfg_type                   cfg,
   input  logic                           issue_valid,
   output logic                           issue_ready,
   input  logic [$clog2(MAX_COLS)-1:0]    in_col,
   input  logic [$clog2(MAX_ROWS)-1:0]    in_row,
   input  logic [DEPTH_W-1:0]             in_depth,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic signed [COORD_W-1:0]      rsp_point_x,
   output logic signed [COORD_W-1:0]      rsp_point_y,
   output logic [DEPTH_W-1:0]             rsp_point_z,
   output logic [PIX_W-1:0]               rsp_pixel_col,
   output logic [PIX_W-1:0]               rsp_pixel_row
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int OCW = $clog2(OUT_DEPTH+1);
   localparam int SW  = $clog2(OUT_DEPTH+PROJ_LAT+1);
   localparam int OW  = 2*COORD_W + DEPTH_W + 2*PIX_W;

   logic [PROJ_LAT-1:0]  vld_ff, vld_in;
   logic [DEPTH_W-1:0]   d_ff   [PROJ_LAT];
   logic [PIX_W-1:0]     col_ff [PROJ_LAT];
   logic [PIX_W-1:0]     row_ff [PROJ_LAT];
   logic [CW+PIX_W-1:0]  col_ext;
   logic [RW+PIX_W-1:0]  row_ext;
   logic [SW-1:0]        inflight, used;
   logic [OCW-1:0]       out_count;
   logic                 issue;
   logic signed [COORD_W-1:0] x_coord, y_coord;
   logic [OW-1:0]        out_wdata, out_rdata;

   // Credit check: every point in flight has a reserved result slot.
   always_comb begin
      inflight = '0;
      for (int i = 0; i < PROJ_LAT; i++) begin
         inflight = inflight + SW'(vld_ff[i]);
      end
      used        = inflight + SW'(out_count);
      issue_ready = (used < SW'(OUT_DEPTH));
      issue       = issue_valid && issue_ready;
      vld_in      = {vld_ff[PROJ_LAT-2:0], issue};
      col_ext     = (CW+PIX_W)'(in_col);
      row_ext     = (RW+PIX_W)'(in_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff[0]   <= in_depth;
      col_ff[0] <= col_ext[PIX_W-1:0];
      row_ff[0] <= row_ext[PIX_W-1:0];
      for (int i = 1; i < PROJ_LAT; i++) begin
         d_ff[i]   <= d_ff[i-1];
         col_ff[i] <= col_ff[i-1];
         row_ff[i] <= row_ff[i-1];
      end
   end

   dmbp_proj #(.PW(CW)) u_proj_x (
      .clock  (clock),
      .pos    (in_col),
      .center (cfg.center_x),
      .depth  (in_depth),
      .inv    (cfg.inv_focal_x),
      .coord  (x_coord)
   );

   dmbp_proj #(.PW(RW)) u_proj_y (
      .clock  (clock),
      .pos    (in_row),
      .center (cfg.center_y),
      .depth  (in_depth),
      .inv    (cfg.inv_focal_y),
      .coord  (y_coord)
   );

   assign out_wdata = {x_coord, y_coord, d_ff[PROJ_LAT-1],
                       col_ff[PROJ_LAT-1], row_ff[PROJ_LAT-1]};

   dmbp_queue #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (vld_ff[PROJ_LAT-1]),
      .push_data (out_wdata),
      .pop       (rsp_pop && !rsp_empty),
      .pop_data  (out_rdata),
      .count     (out_count)
   );

   assign rsp_empty = (out_count == '0);
   assign {rsp_point_x, rsp_point_y, rsp_point_z, rsp_pixel_col, rsp_pixel_row} = out_rdata;

endmodule

>>> src/depth_map_backprojection.sv
// ----------------------------------------------------------------------------
// Depth map back-projection
// Turns a raster stream of depth samples into 3-D points of a pinhole camera.
// ----------------------------------------------------------------------------
// Depth samples enter through the request queue port: a request is taken at a
// rising edge with req_push high and req_full low. Each request is one pixel in
// raster order; req_frame_start marks column and row zero of a new frame.
// Pixels off the decimation grid, with zero depth or outside the depth window
// give no result. Every other request yields one point on the result queue
// port: while rsp_empty is low the oldest point is on the rsp_ ports, and it is
// removed at an edge with rsp_pop high. The block takes one request per cycle
// without pause as long as results are drained; the rate is set by the front
// counters, which are updated at the edge that takes each request. The middle
// queue is written at that edge; when the result queue has room the request is
// issued to the five projection stages (subtract, two multiplies, sum, round
// and saturate), and their result is written into the result queue and then
// shows on the rsp_ ports, ready to be popped. When rsp_pop is held low the
// result queue fills, issue from the middle queue stops, and req_full rises
// once the four-entry middle queue is full. Synchronous reset empties both
// queues, clears the position counters and returns all registers to their
// defaults. Registers are written through the csr_ port, which is always ready.
// ----------------------------------------------------------------------------
module depth_map_backprojection
   import dmbp_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [DEPTH_W-1:0]        req_depth_mm,
   input  logic                      req_frame_start,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [DEPTH_W-1:0]        rsp_point_z,
   output logic [PIX_W-1:0]          rsp_pixel_col,
   output logic [PIX_W-1:0]          rsp_pixel_row,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [3:0]                csr_index,
   input  logic [31:0]               csr_data
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int RW  = $clog2(MAX_ROWS);
   localparam int MCW = $clog2(MID_DEPTH+1);
   localparam int MW  = CW + RW + DEPTH_W;

   front_cfg_type front_cfg_ff, front_cfg_in;
   back_cfg_type  back_cfg_ff, back_cfg_in;

   logic          req_accept;
   logic          keep;
   logic [CW-1:0] front_col, mid_col;
   logic [RW-1:0] front_row, mid_row;
   logic [DEPTH_W-1:0] mid_depth;
   logic [MW-1:0] mid_rdata;
   logic [MCW-1:0] mid_count;
   logic          mid_valid, mid_pop, back_ready;

   // Register file. Writes keep the low bits of each register's width, and
   // indexes past the last register are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      front_cfg_in = front_cfg_ff;
      back_cfg_in  = back_cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_DEPTH_LO:    front_cfg_in.depth_lo    = csr_data[15:0];
            REG_DEPTH_HI:    front_cfg_in.depth_hi    = csr_data[15:0];
            REG_CENTER_X:    back_cfg_in.center_x     = csr_data[15:0];
            REG_CENTER_Y:    back_cfg_in.center_y     = csr_data[15:0];
            REG_INV_FOCAL_X: back_cfg_in.inv_focal_x  = csr_data;
            REG_INV_FOCAL_Y: back_cfg_in.inv_focal_y  = csr_data;
            REG_DEC_STEP:    front_cfg_in.dec_step    = csr_data[5:0];
            REG_IMAGE_WIDTH: front_cfg_in.image_width = csr_data[12:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff.depth_lo    <= RST_DEPTH_LO;
         front_cfg_ff.depth_hi    <= RST_DEPTH_HI;
         front_cfg_ff.dec_step    <= RST_DEC_STEP;
         front_cfg_ff.image_width <= RST_IMAGE_WIDTH;
         back_cfg_ff.center_x     <= RST_CENTER_X;
         back_cfg_ff.center_y     <= RST_CENTER_Y;
         back_cfg_ff.inv_focal_x  <= RST_INV_FOCAL;
         back_cfg_ff.inv_focal_y  <= RST_INV_FOCAL;
      end else begin
         front_cfg_ff <= front_cfg_in;
         back_cfg_ff  <= back_cfg_in;
      end
   end

   // The front stalls only on a full middle queue; a request that is dropped
   // still advances the position counters.
   assign req_full   = (mid_count == MCW'(MID_DEPTH));
   assign req_accept = req_push && !req_full;

   dmbp_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .depth_mm    (req_depth_mm),
      .frame_start (req_frame_start),
      .cfg         (front_cfg_ff),
      .keep        (keep),
      .col         (front_col),
      .row         (front_row)
   );

   // Middle queue: decouples the front from the credit-limited back end.
   dmbp_queue #(.WIDTH(MW), .DEPTH(MID_DEPTH)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept && keep),
      .push_data ({front_col, front_row, req_depth_mm}),
      .pop       (mid_pop),
      .pop_data  (mid_rdata),
      .count     (mid_count)
   );

   assign {mid_col, mid_row, mid_depth} = mid_rdata;
   assign mid_valid = (mid_count != '0);
   assign mid_pop   = mid_valid && back_ready;

   dmbp_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (back_cfg_ff),
      .issue_valid   (mid_valid),
      .issue_ready   (back_ready),
      .in_col        (mid_col),
      .in_row        (mid_row),
      .in_depth      (mid_depth),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_point_z   (rsp_point_z),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row)
   );

`ifndef SYNTH
   // The middle queue never holds more than its depth.
   a_mid_bound: assert property (@(posedge clock) disable iff (reset)
      mid_count <= MCW'(MID_DEPTH))
      else $error("middle queue count exceeds its depth");

   // After reset both sides are empty and open.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // A kept request is waiting in the middle queue in the next cycle.
   a_kept_queued: assert property (@(posedge clock) disable iff (reset)
      (req_accept && keep) |=> (mid_count != '0))
      else $error("kept request missing from middle queue");

   // Nothing is issued to the back end from an empty middle queue.
   a_no_empty_issue: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> mid_valid)
      else $error("issue from empty middle queue");
`endif

endmodule

>>> verif/depth_map_backprojection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth map back-projection testbench
// Streams depth pixels into the block, predicts every 3-D point it must emit
// from a behavioral copy of the counters and the projection arithmetic, and
// compares each popped point with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module depth_map_backprojection_tb;
   import dmbp_pkg::*;

   // Cycles allowed after the last expected point before the block is
   // treated as idle. Rejected pixels are dropped at the front, so this is
   // only margin before the next register write.
   localparam int SETTLE_CYCLES = 20;
   localparam int RANDOM_ITEMS  = 850;
   localparam longint COORD_HI  = 64'sd8388607;
   localparam longint COORD_LO  = -64'sd8388608;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [DEPTH_W-1:0]        z;
      logic [PIX_W-1:0]          col;
      logic [PIX_W-1:0]          row;
   } point_t;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [DEPTH_W-1:0]        req_depth_mm = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic [DEPTH_W-1:0]        rsp_point_z;
   logic [PIX_W-1:0]          rsp_pixel_col;
   logic [PIX_W-1:0]          rsp_pixel_row;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [3:0]                csr_index = '0;
   logic [31:0]               csr_data = '0;

   // Shadow copy of the configuration registers.
   logic [15:0] cfg_depth_lo;
   logic [15:0] cfg_depth_hi;
   logic [15:0] cfg_center_x;
   logic [15:0] cfg_center_y;
   logic [31:0] cfg_inv_fx;
   logic [31:0] cfg_inv_fy;
   logic [5:0]  cfg_dec_step;
   logic [12:0] cfg_width;

   // Raster position of the next pixel and its place in the decimation grid.
   logic [11:0] pos_col;
   logic [11:0] pos_row;
   logic [5:0]  phase_col;
   logic [5:0]  phase_row;

   point_t pending_points[$];
   int     mismatches = 0;

   // When steady is set neither side idles. rsp_hold_req asks the result
   // side to hold off popping for that many cycles.
   bit     steady = 1'b0;
   int     rsp_hold_req = 0;
   int     pop_wait = 0;

   depth_map_backprojection uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_depth_mm    (req_depth_mm),
      .req_frame_start (req_frame_start),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic void reset_shadow();
      cfg_depth_lo = RST_DEPTH_LO;
      cfg_depth_hi = RST_DEPTH_HI;
      cfg_center_x = RST_CENTER_X;
      cfg_center_y = RST_CENTER_Y;
      cfg_inv_fx   = RST_INV_FOCAL;
      cfg_inv_fy   = RST_INV_FOCAL;
      cfg_dec_step = RST_DEC_STEP;
      cfg_width    = RST_IMAGE_WIDTH;
      pos_col   = '0;
      pos_row   = '0;
      phase_col = '0;
      phase_row = '0;
   endfunction

   // Each register keeps only the low bits of its own width; indexes past
   // the last register are dropped by the block.
   function automatic void apply_reg(logic [3:0] index, logic [31:0] value);
      case (index)
         REG_DEPTH_LO:    cfg_depth_lo = value[15:0];
         REG_DEPTH_HI:    cfg_depth_hi = value[15:0];
         REG_CENTER_X:    cfg_center_x = value[15:0];
         REG_CENTER_Y:    cfg_center_y = value[15:0];
         REG_INV_FOCAL_X: cfg_inv_fx   = value;
         REG_INV_FOCAL_Y: cfg_inv_fy   = value;
         REG_DEC_STEP:    cfg_dec_step = value[5:0];
         REG_IMAGE_WIDTH: cfg_width    = value[12:0];
         default: ;
      endcase
   endfunction

   // floor((16*pos - center) * depth * inv / 2^36), clamped to 24-bit signed.
   // The full product is at most about 2^65 in magnitude, so an 80-bit signed
   // product and an arithmetic shift give the floor directly.
   function automatic logic signed [COORD_W-1:0] backproject(logic [11:0] pos,
         logic [15:0] center, logic [15:0] depth, logic [31:0] inv);
      logic signed [79:0] offset;
      logic signed [79:0] scaled;
      offset = $signed({64'd0, pos, 4'd0}) - $signed({64'd0, center});
      scaled = (offset * $signed({64'd0, depth}) * $signed({48'd0, inv})) >>> 36;
      if (scaled > COORD_HI)
         return 24'sh7FFFFF;
      if (scaled < COORD_LO)
         return 24'sh800000;
      return scaled[COORD_W-1:0];
   endfunction

   // Advances the shadow raster position by one accepted pixel and queues the
   // point the block must emit for it, if any.
   function automatic void project_pixel(logic [15:0] depth, logic frame_start);
      int     step;
      int     width;
      point_t pt;
      step  = (cfg_dec_step == 0) ? 1 : int'(cfg_dec_step);
      width = (cfg_width == 0) ? 1 : int'(cfg_width);
      if (width > MAX_COLS_DEF)
         width = MAX_COLS_DEF;
      if (frame_start) begin
         pos_col   = '0;
         pos_row   = '0;
         phase_col = '0;
         phase_row = '0;
      end
      if (phase_col == 0 && phase_row == 0 && depth != 0 &&
          depth >= cfg_depth_lo && depth <= cfg_depth_hi) begin
         pt.x   = backproject(pos_col, cfg_center_x, depth, cfg_inv_fx);
         pt.y   = backproject(pos_row, cfg_center_y, depth, cfg_inv_fy);
         pt.z   = depth;
         pt.col = pos_col;
         pt.row = pos_row;
         pending_points.insert(pending_points.size(), pt);
      end
      // A phase that is already past a lowered step falls back to zero on
      // its next advance. The row counter, and with it the row phase, stops
      // at the last row.
      if (int'(pos_col) + 1 >= width) begin
         pos_col   = '0;
         phase_col = '0;
         if (int'(pos_row) + 1 < MAX_ROWS_DEF) begin
            pos_row   = pos_row + 1'b1;
            phase_row = (int'(phase_row) + 1 >= step) ? 6'd0 : phase_row + 1'b1;
         end
      end else begin
         pos_col   = pos_col + 1'b1;
         phase_col = (int'(phase_col) + 1 >= step) ? 6'd0 : phase_col + 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return 0;
      if (r < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offers one pixel request and returns at the edge that accepted it.
   // Called at a rising edge; push stays high when the next request follows
   // without a gap.
   task automatic send_pixel(input logic [15:0] depth, input logic frame_start);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_depth_mm    <= depth;
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      project_pixel(depth, frame_start);
   endtask

   task automatic write_reg(input logic [3:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      apply_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stops offering requests and waits until every predicted point is out.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Pop with random gaps; a hold request forces one long stretch with pop
   // low so that the result queue and then the middle queue fill up.
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         pop_wait = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (pop_wait > 0) begin
         rsp_pop <= 1'b0;
         pop_wait--;
      end else begin
         rsp_pop <= 1'b1;
         pop_wait = steady ? 0 : idle_length();
      end
   end

   function automatic void compare_field(string name, longint want, longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // Every popped point is matched against the oldest prediction.
   always @(posedge clock) begin : check_points
      point_t want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_points.size() == 0) begin
            mismatches++;
            $display("%0t: point with none expected, actual x %0d y %0d z %0d col %0d row %0d",
                     $time, rsp_point_x, rsp_point_y, rsp_point_z, rsp_pixel_col,
                     rsp_pixel_row);
         end else begin
            want = pending_points.pop_front();
            compare_field("point_x", longint'(want.x), longint'(rsp_point_x));
            compare_field("point_y", longint'(want.y), longint'(rsp_point_y));
            compare_field("point_z", longint'(want.z), longint'(rsp_point_z));
            compare_field("pixel_col", longint'(want.col), longint'(rsp_pixel_col));
            compare_field("pixel_row", longint'(want.row), longint'(rsp_pixel_row));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Short directed walk: default registers, depth extremes, the depth window
   // edges, inverted limits, register masking, saturation, a zero step, a
   // zero width and a write to an index past the last register.
   task automatic test_directed();
      send_pixel(16'd1000, 1'b1);
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd65535, 1'b0);
      send_pixel(16'd1, 1'b0);
      wait_idle();

      // Window edges: just below, on both limits, just above.
      write_reg(REG_DEPTH_LO, 32'd100);
      write_reg(REG_DEPTH_HI, 32'd200);
      send_pixel(16'd99, 1'b0);
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd200, 1'b0);
      send_pixel(16'd201, 1'b0);
      wait_idle();

      // With the minimum above the maximum nothing may pass.
      write_reg(REG_DEPTH_LO, 32'd300);
      send_pixel(16'd250, 1'b0);
      send_pixel(16'd300, 1'b0);
      wait_idle();

      // Upper data bits must be dropped. The y offset is hugely negative and
      // the reciprocals are at their largest, so y saturates low.
      write_reg(REG_DEPTH_LO, 32'hABCD_0000);
      write_reg(REG_DEPTH_HI, 32'h1234_FFFF);
      write_reg(REG_CENTER_X, 32'd0);
      write_reg(REG_CENTER_Y, 32'h0000_FFFF);
      write_reg(REG_INV_FOCAL_X, 32'hFFFF_FFFF);
      write_reg(REG_INV_FOCAL_Y, 32'hFFFF_FFFF);
      write_reg(REG_IMAGE_WIDTH, 32'd4);
      send_pixel(16'd65535, 1'b1);
      send_pixel(16'd65535, 1'b0);
      send_pixel(16'd65535, 1'b0);
      send_pixel(16'd65535, 1'b0);
      send_pixel(16'd65535, 1'b0);
      wait_idle();

      // A step of zero keeps everything; a width of zero makes each pixel a
      // row of its own.
      write_reg(REG_DEC_STEP, 32'd0);
      write_reg(REG_IMAGE_WIDTH, 32'd0);
      send_pixel(16'd500, 1'b1);
      send_pixel(16'd500, 1'b0);
      send_pixel(16'd500, 1'b0);
      wait_idle();

      // The stray write must leave every register alone.
      write_reg(4'($urandom_range(8, 15)), $urandom);
      write_reg(REG_INV_FOCAL_X, 32'd0);
      send_pixel(16'd700, 1'b0);
      wait_idle();
   endtask

   // Lowers the step while the column phase sits past the new period.
   task automatic test_decimation_change();
      write_reg(REG_CENTER_X, 32'd5120);
      write_reg(REG_CENTER_Y, 32'd3840);
      write_reg(REG_INV_FOCAL_X, 32'd8589934);
      write_reg(REG_INV_FOCAL_Y, 32'd8589934);
      write_reg(REG_IMAGE_WIDTH, 32'd16);
      write_reg(REG_DEC_STEP, 32'd4);
      send_pixel(16'd800, 1'b1);
      for (int i = 0; i < 5; i++)
         send_pixel(16'd800, 1'b0);
      wait_idle();
      write_reg(REG_DEC_STEP, 32'd2);
      for (int i = 0; i < 5; i++)
         send_pixel(16'(810 + i), 1'b0);
      wait_idle();
   endtask

   // A width above the column limit acts as the limit, so one long row runs
   // on and x saturates high at the far columns. Then one-pixel rows with a
   // step of two, where every other row is off the grid.
   task automatic test_frame_limits();
      steady = 1'b1;
      write_reg(REG_IMAGE_WIDTH, 32'h0000_1FFF);
      write_reg(REG_DEC_STEP, 32'd1);
      write_reg(REG_CENTER_X, 32'd0);
      write_reg(REG_CENTER_Y, 32'd0);
      write_reg(REG_INV_FOCAL_X, 32'hFFFF_FFFF);
      for (int i = 0; i < 200; i++)
         send_pixel((i >= 120) ? 16'd65535 : 16'd0, i == 0);
      wait_idle();
      write_reg(REG_IMAGE_WIDTH, 32'd1);
      write_reg(REG_DEC_STEP, 32'd2);
      for (int i = 0; i < 40; i++)
         send_pixel(16'(1000 + i), i == 0);
      wait_idle();
      steady = 1'b0;
   endtask

   // The result side holds off for a long stretch while requests keep
   // coming every cycle, so the block must fill and raise req_full.
   task automatic test_backpressure();
      write_reg(REG_IMAGE_WIDTH, 32'd16);
      write_reg(REG_DEC_STEP, 32'd1);
      write_reg(REG_DEPTH_LO, 32'd1);
      steady = 1'b1;
      rsp_hold_req = 60;
      for (int i = 0; i < 48; i++)
         send_pixel(16'($urandom_range(1, 65535)), i == 0);
      steady = 1'b0;
      wait_idle();
   endtask

   function automatic logic [15:0] pick_coord16();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'd0;
      if (r == 1)
         return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   // A fresh setting of all registers; junk in the upper data bits checks
   // that each register keeps only its own width.
   task automatic randomize_config();
      int          r;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [31:0] inv;
      logic [12:0] width;
      logic [5:0]  step;

      r = $urandom_range(0, 99);
      if (r < 15) begin
         lo = 16'd0;
         hi = 16'hFFFF;
      end else if (r < 25) begin
         hi = 16'($urandom_range(0, 60000));
         lo = hi + 16'($urandom_range(1, 5000));
      end else begin
         lo = 16'($urandom_range(0, 2000));
         hi = ($urandom_range(0, 3) == 0) ? 16'hFFFF : lo + 16'($urandom_range(0, 40000));
      end
      write_reg(REG_DEPTH_LO, ($urandom & 32'hFFFF_0000) | 32'(lo));
      write_reg(REG_DEPTH_HI, ($urandom & 32'hFFFF_0000) | 32'(hi));
      write_reg(REG_CENTER_X, ($urandom & 32'hFFFF_0000) | 32'(pick_coord16()));
      write_reg(REG_CENTER_Y, ($urandom & 32'hFFFF_0000) | 32'(pick_coord16()));

      for (int k = 0; k < 2; k++) begin
         r = $urandom_range(0, 99);
         if (r < 10)
            inv = 32'd0;
         else if (r < 20)
            inv = 32'hFFFF_FFFF;
         else if (r < 40)
            inv = $urandom;
         else
            inv = $urandom_range(1000000, 30000000);
         write_reg((k == 0) ? REG_INV_FOCAL_X : REG_INV_FOCAL_Y, inv);
      end

      r = $urandom_range(0, 99);
      if (r < 10)
         step = 6'd0;
      else if (r < 70)
         step = 6'($urandom_range(1, 4));
      else if (r < 90)
         step = 6'($urandom_range(5, 12));
      else
         step = 6'd63;
      write_reg(REG_DEC_STEP, ($urandom & 32'hFFFF_FFC0) | 32'(step));

      r = $urandom_range(0, 99);
      if (r < 6)
         width = 13'd0;
      else if (r < 70)
         width = 13'($urandom_range(1, 24));
      else if (r < 90)
         width = 13'($urandom_range(25, 700));
      else
         width = 13'($urandom_range(4090, 8191));
      write_reg(REG_IMAGE_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(width));

      if ($urandom_range(0, 4) == 0)
         write_reg(4'($urandom_range(8, 15)), $urandom);
   endtask

   // Mostly depths inside the current window, with zeros, the full range
   // and the values right on and just past the limits mixed in.
   function automatic logic [15:0] random_depth();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 16'd0;
      if (r < 18)
         return 16'($urandom_range(0, 65535));
      if (r < 26) begin
         case ($urandom_range(0, 5))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return cfg_depth_lo;
            3: return cfg_depth_hi;
            4: return cfg_depth_lo - 1'b1;
            default: return cfg_depth_hi + 1'b1;
         endcase
      end
      if (cfg_depth_lo <= cfg_depth_hi)
         return 16'($urandom_range(cfg_depth_lo, cfg_depth_hi));
      return 16'($urandom_range(0, 65535));
   endfunction

   // Phases of random requests, each under a new register setting. The
   // counters run on across phases unless a frame start clears them, so
   // step and width changes also land mid-stream.
   task automatic test_random();
      int items_done;
      int phase_len;
      items_done = 0;
      while (items_done < RANDOM_ITEMS) begin
         wait_idle();
         randomize_config();
         steady = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(120, 260);
         for (int i = 0; i < phase_len; i++)
            send_pixel(random_depth(),
                       (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 3));
         items_done += phase_len;
         steady = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_decimation_change();
      test_frame_limits();
      test_backpressure();
      test_random();
      wait_idle();
      if (mismatches == 0 && pending_points.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // The slowest correct run stays well below this.
   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

endmodule
